// ===== src/atrm_pkg.sv =====
// Types and constants shared by the AT response matcher files.
`timescale 1ns / 1ps

package atrm_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_OK     = 2'd1,
    ST_RESEND = 2'd2,
    ST_FAIL   = 2'd3
  } status_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT  = 1'd0,
    CFG_ATTEMPTS = 1'd1
  } cfg_idx_t;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd200;
  localparam logic [7:0]  ATTEMPTS_RESET = 8'd30;
  localparam logic [15:0] TICKS_MAX      = 16'hFFFF;

  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_R = 8'h52;

  localparam logic [2:0] ERR_E   = 3'd1;
  localparam logic [2:0] ERR_ER  = 3'd2;
  localparam logic [2:0] ERR_ERR = 3'd3;
  localparam logic [2:0] ERR_ERO = 3'd4;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    logic       capture_enable;
    logic [6:0] capture_limit;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] received_count;
    logic       capture_valid;
    logic [6:0] capture_index;
    logic [7:0] capture_byte;
  } out_item_t;

  typedef struct packed {
    logic        listening;
    logic        ok_progress;
    logic [2:0]  error_progress;
    logic [7:0]  attempts_used;
    logic [15:0] elapsed_ticks;
    logic [7:0]  byte_count;
    logic [6:0]  capture_position;
    logic        capture_on;
    logic [6:0]  capture_max;
  } state_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  max_attempts;
  } cfg_t;

endpackage

// ===== src/atrm_if.sv =====
// Valid/ready stream interfaces for the input items and the result items.
`timescale 1ns / 1ps

interface atrm_in_if;
  import atrm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface atrm_out_if;
  import atrm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/atrm_step.sv =====
// Next-state and result logic for one item of the AT response matcher.
`timescale 1ns / 1ps

module atrm_step (
  input  atrm_pkg::state_t    state_i,
  input  atrm_pkg::in_item_t  item_i,
  input  atrm_pkg::cfg_t      cfg_i,
  output atrm_pkg::state_t    state_nxt,
  output atrm_pkg::out_item_t result_o
);
  import atrm_pkg::*;

  state_t      n;
  out_item_t   o;
  logic        ok_done;
  logic        end_att;
  logic [15:0] elapsed_inc;
  logic        cap_room;

  assign elapsed_inc = (state_i.elapsed_ticks < TICKS_MAX) ?
                       state_i.elapsed_ticks + 16'd1 : state_i.elapsed_ticks;
  assign cap_room    = ({1'b0, state_i.capture_position} + 8'd1) <
                       {1'b0, state_i.capture_max};

  always_comb begin
    n       = state_i;
    o       = '0;
    o.status = ST_BUSY;
    o.received_count = state_i.byte_count;
    ok_done = 1'b0;
    end_att = 1'b0;

    unique case (item_i.op)
      OP_START: begin
        n.listening        = 1'b1;
        n.attempts_used    = 8'd1;
        n.capture_on       = item_i.capture_enable;
        n.capture_max      = item_i.capture_limit;
        n.ok_progress      = 1'b0;
        n.error_progress   = 3'd0;
        n.elapsed_ticks    = 16'd0;
        n.byte_count       = 8'd0;
        n.capture_position = 7'd0;
        o.received_count   = 8'd0;
      end
      OP_BYTE: begin
        if (state_i.listening) begin
          if (state_i.capture_on) begin
            n.byte_count = state_i.byte_count + 8'd1;
            if (cap_room) begin
              o.capture_valid    = 1'b1;
              o.capture_index    = state_i.capture_position;
              o.capture_byte     = item_i.rx_byte;
              n.capture_position = state_i.capture_position + 7'd1;
            end
          end
          o.received_count = n.byte_count;

          priority if (item_i.rx_byte == CH_O) begin
            n.ok_progress = 1'b1;
          end else if (item_i.rx_byte == CH_K && state_i.ok_progress) begin
            ok_done = 1'b1;
          end else begin
            n.ok_progress = 1'b0;
          end

          if (ok_done) begin
            n.listening = 1'b0;
            o.status    = ST_OK;
          end else begin
            priority if (item_i.rx_byte == CH_E) begin
              n.error_progress = ERR_E;
            end else if (item_i.rx_byte == CH_R && (state_i.error_progress == ERR_E ||
                         state_i.error_progress == ERR_ER)) begin
              n.error_progress = state_i.error_progress + 3'd1;
            end else if (item_i.rx_byte == CH_O && state_i.error_progress == ERR_ERR) begin
              n.error_progress = ERR_ERO;
            end else if (item_i.rx_byte == CH_R && state_i.error_progress == ERR_ERO) begin
              end_att = 1'b1;
            end else begin
              n.error_progress = 3'd0;
            end
          end
        end
      end
      OP_TICK: begin
        if (state_i.listening) begin
          n.elapsed_ticks = elapsed_inc;
          if (elapsed_inc >= cfg_i.timeout_ticks) begin
            end_att = 1'b1;
          end
        end
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase

    // end of attempt: retry or give up
    if (end_att) begin
      if (state_i.attempts_used >= cfg_i.max_attempts) begin
        n.listening = 1'b0;
        o.status    = ST_FAIL;
      end else begin
        n.attempts_used    = state_i.attempts_used + 8'd1;
        n.ok_progress      = 1'b0;
        n.error_progress   = 3'd0;
        n.elapsed_ticks    = 16'd0;
        n.byte_count       = 8'd0;
        n.capture_position = 7'd0;
        o.status           = ST_RESEND;
      end
    end
  end

  assign state_nxt = n;
  assign result_o  = o;

endmodule

// ===== src/at_response_matcher_top.sv =====
// Top level of the AT response matcher: input register, state and result register.
`timescale 1ns / 1ps

// Watches the reply of an AT command exchange. Each input transfer (start, reply byte,
// millisecond tick or none) gives exactly one result transfer carrying the exchange
// status, the byte count of the attempt (counted only while capture is on) and, when
// capture is on and has room, the captured byte with its index. One item is taken
// every clock cycle while the result side keeps up; a result is offered once its item
// has passed through the input register into the result register, and the matcher
// state is updated once per item, which bounds the rate at one item per cycle.
// Configuration writes are taken at any cycle but belong only to idle periods.
module at_response_matcher_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  atrm_in_if.sink                              in_ch,
  atrm_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [atrm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [atrm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import atrm_pkg::*;

  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  state_t    state_r;
  state_t    state_nxt;
  out_item_t step_out;
  cfg_t      cfg_r;
  logic      advance;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  atrm_step u_step (
    .state_i   (state_r),
    .item_i    (in_data_r),
    .cfg_i     (cfg_r),
    .state_nxt (state_nxt),
    .result_o  (step_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r <= in_ch.data;
    end
    if (advance) begin
      out_data_r <= step_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
      cfg_r.max_attempts  <= ATTEMPTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIMEOUT:  cfg_r.timeout_ticks <= cfg_wdata;
        CFG_ATTEMPTS: cfg_r.max_attempts  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ch.ready)
    else $error("input stage empty but not ready");

  a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item produced no result");

  a_ok_stops_listening: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step_out.status == ST_OK) |=> !state_r.listening)
    else $error("exchange still listening after OK");

  a_attempts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.listening |-> state_r.attempts_used != 8'd0)
    else $error("listening with no attempt counted");

endmodule

// ===== bench/at_response_matcher_checker.sv =====
// Checker for the AT response matcher: predicts each result and compares it with the block.
`timescale 1ns / 1ps

module at_response_matcher_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  atrm_in_if                              in_mon,
  atrm_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [atrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atrm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import atrm_pkg::*;

  logic [15:0] tick_limit;
  logic [7:0]  try_limit;

  logic        armed;
  logic        ok_seen;
  logic [2:0]  err_stage;
  logic [7:0]  tries;
  logic [15:0] ticks;
  logic [7:0]  nbytes;
  logic [6:0]  cap_pos;
  logic        cap_en;
  logic [6:0]  cap_len;

  out_item_t awaited_replies[$];

  function automatic void open_attempt();
    ok_seen   = 1'b0;
    err_stage = 3'd0;
    ticks     = 16'd0;
    nbytes    = 8'd0;
    cap_pos   = 7'd0;
  endfunction

  function automatic status_t close_attempt();
    if (tries >= try_limit) begin
      armed = 1'b0;
      return ST_FAIL;
    end
    tries = tries + 8'd1;
    open_attempt();
    return ST_RESEND;
  endfunction

  function automatic out_item_t predict_reply(in_item_t it);
    out_item_t r;
    logic      ok_hit;
    logic      err_hit;
    r       = '0;
    ok_hit  = 1'b0;
    err_hit = 1'b0;
    if (it.op == OP_START) begin
      armed   = 1'b1;
      tries   = 8'd1;
      cap_en  = it.capture_enable;
      cap_len = it.capture_limit;
      open_attempt();
      r.received_count = 8'd0;
    end else if (it.op == OP_BYTE && armed) begin
      if (cap_en) begin
        nbytes = nbytes + 8'd1;
        if (({1'b0, cap_pos} + 8'd1) < {1'b0, cap_len}) begin
          r.capture_valid = 1'b1;
          r.capture_index = cap_pos;
          r.capture_byte  = it.rx_byte;
          cap_pos = cap_pos + 7'd1;
        end
      end
      r.received_count = nbytes;
      if (it.rx_byte == CH_O) begin
        ok_seen = 1'b1;
      end else if (it.rx_byte == CH_K && ok_seen) begin
        ok_hit = 1'b1;
      end else begin
        ok_seen = 1'b0;
      end
      if (ok_hit) begin
        armed    = 1'b0;
        r.status = ST_OK;
      end else begin
        if (it.rx_byte == CH_E)
          err_stage = ERR_E;
        else if (it.rx_byte == CH_R && (err_stage == ERR_E || err_stage == ERR_ER))
          err_stage = err_stage + 3'd1;
        else if (it.rx_byte == CH_O && err_stage == ERR_ERR)
          err_stage = ERR_ERO;
        else if (it.rx_byte == CH_R && err_stage == ERR_ERO)
          err_hit = 1'b1;
        else
          err_stage = 3'd0;
        if (err_hit)
          r.status = close_attempt();
      end
    end else if (it.op == OP_TICK && armed) begin
      if (ticks != TICKS_MAX)
        ticks = ticks + 16'd1;
      r.received_count = nbytes;
      if (ticks >= tick_limit)
        r.status = close_attempt();
    end else begin
      r.received_count = nbytes;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      tick_limit = TIMEOUT_RESET;
      try_limit  = ATTEMPTS_RESET;
      armed      = 1'b0;
      tries      = 8'd0;
      cap_en     = 1'b0;
      cap_len    = 7'd0;
      open_attempt();
      awaited_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT:  tick_limit = cfg_wdata;
          CFG_ATTEMPTS: try_limit = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (awaited_replies.size() == 0) begin
          $error("unexpected result transfer: status %0d count %0d",
                 got.status, got.received_count);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.received_count !== want.received_count) begin
            $error("received_count: expected %0d, got %0d",
                   want.received_count, got.received_count);
            fail_count++;
          end
          if (got.capture_valid !== want.capture_valid) begin
            $error("capture_valid: expected %0d, got %0d",
                   want.capture_valid, got.capture_valid);
            fail_count++;
          end
          if (got.capture_index !== want.capture_index) begin
            $error("capture_index: expected %0d, got %0d",
                   want.capture_index, got.capture_index);
            fail_count++;
          end
          if (got.capture_byte !== want.capture_byte) begin
            $error("capture_byte: expected %0h, got %0h",
                   want.capture_byte, got.capture_byte);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        awaited_replies.push_back(predict_reply(in_mon.data));
    end
    pending = awaited_replies.size();
  end

endmodule

// ===== bench/at_response_matcher_top_tb.sv =====
// Testbench top for the AT response matcher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module at_response_matcher_top_tb;
  import atrm_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  rx_ready = 1'b0;

  int fail_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent_items = 0;
  int quiet_cycles = 0;

  atrm_in_if  in_ch ();
  atrm_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  at_response_matcher_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  at_response_matcher_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    rx_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** at_response_matcher_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_item(input op_t op, input logic [7:0] b, input logic en,
                           input logic [6:0] lim);
    in_item_t it;
    it.op             = op;
    it.rx_byte        = b;
    it.capture_enable = en;
    it.capture_limit  = lim;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(OP_BYTE, s[i], 1'b0, 7'd0);
  endtask

  // hold the input side quiet until every outstanding result has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_config(input logic [15:0] tmo, input logic [7:0] att);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(negedge clk);
    cfg_index <= CFG_ATTEMPTS;
    cfg_wdata <= {8'd0, att};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic        en;
    logic [6:0]  lim;
    logic [15:0] tmo;
    logic [7:0]  att;
    int          chunks;
    int          pick;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    send_item(OP_BYTE, 8'hFF, 1'b1, 7'd127);
    send_item(OP_TICK, 8'h00, 1'b0, 7'd0);
    send_item(OP_NONE, 8'h00, 1'b0, 7'd0);
    send_item(OP_START, 8'h00, 1'b1, 7'd127);
    send_item(OP_BYTE, 8'h00, 1'b0, 7'd0);
    send_word("OK");
    send_item(OP_START, 8'hFF, 1'b1, 7'd0);
    send_word("ERROR");
    send_item(OP_TICK, 8'h00, 1'b0, 7'd0);
    send_item(OP_START, 8'h00, 1'b0, 7'd1);
    send_item(OP_BYTE, 8'hFF, 1'b0, 7'd0);
    set_config(16'd0, 8'd0);
    send_item(OP_START, 8'h00, 1'b1, 7'd1);
    send_item(OP_TICK, 8'h00, 1'b0, 7'd0);
    send_word("O");
    set_config(16'd1, 8'd2);
    send_item(OP_START, 8'h00, 1'b1, 7'd2);
    send_item(OP_BYTE, 8'h55, 1'b0, 7'd0);
    send_item(OP_BYTE, 8'hAA, 1'b0, 7'd0);
    send_item(OP_TICK, 8'h00, 1'b0, 7'd0);
    send_item(OP_TICK, 8'h00, 1'b0, 7'd0);
    set_config(16'hFFFF, 8'd255);
    send_item(OP_START, 8'h00, 1'b1, 7'd3);
    send_word("OK");

    // random part
    for (int blk = 0; blk < 4 || sent_items < 650; blk++) begin
      case (blk % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      pick = $urandom_range(9);
      tmo  = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd1 : 16'($urandom_range(1, 10));
      pick = $urandom_range(9);
      att  = (pick == 0) ? 8'd255 : (pick == 1) ? 8'd1 : 8'($urandom_range(1, 5));
      set_config(tmo, att);

      if (blk == 2) begin
        // long capture run: the byte count wraps and the index climbs to 125, its last value under the limit of 127
        send_item(OP_START, 8'h00, 1'b1, 7'd127);
        repeat (300) send_item(OP_BYTE, 8'($urandom_range(8'h3F)), 1'b0, 7'd0);
        send_word("OK");
      end

      repeat ($urandom_range(3, 6)) begin
        en  = 1'($urandom_range(1));
        lim = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
        send_item(OP_START, 8'($urandom_range(255)), en, lim);
        chunks = $urandom_range(1, 12);
        for (int k = 0; k < chunks; k++) begin
          pick = $urandom_range(11);
          case (pick)
            0: send_word("OK");
            1: send_word("ERROR");
            2, 3: repeat ($urandom_range(1, 6))
                    send_item(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              7'($urandom_range(127)));
            4: begin
              send_word("ERR");
              send_item(OP_BYTE, 8'($urandom_range(255)), 1'b0, 7'd0);
            end
            5: send_word("OOK");
            6: send_word("ERROK");
            7: send_word("EERRORR");
            8: send_item(OP_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         7'($urandom_range(127)));
            9: send_item(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         7'($urandom_range(12)));
            default: repeat (2)
                       send_item(OP_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                 7'($urandom_range(127)));
          endcase
        end
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("** at_response_matcher_top: PASSED **");
    else
      $display("** at_response_matcher_top: FAILED **");
    $finish;
  end

endmodule
